@@ hw/rtl/pcxw_pkg.sv @@
// ----------------------------------------------------------------------------
// pcxw_pkg
// Shared types, register indexes and constants of the PCX run-length pixel
// word writer.
// ----------------------------------------------------------------------------
package pcxw_pkg;

  // Default screen pitch in 16-bit words
  localparam int LINE_WORDS_DEF = 160;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int RUN_W   = 6;
  localparam int COL_W   = 9;
  localparam int LINE_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int APB_W   = 32;

  // Run header: both top bits set, count in the low six bits
  localparam logic [1:0] RUN_MARK = 2'b11;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LEFT_POS  = 3'd0;
  localparam logic [2:0] REG_TOP_POS   = 3'd1;
  localparam logic [2:0] REG_WIDTH     = 3'd2;
  localparam logic [2:0] REG_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_MEM_BASE  = 3'd4;

  // Reset values of the registers
  localparam logic [COL_W-1:0]  WIDTH_RST  = 9'd320;
  localparam logic [LINE_W-1:0] HEIGHT_RST = 8'd240;

  // Result kinds (tuser on the output)
  localparam logic TGT_ADDR = 1'b0;
  localparam logic TGT_DATA = 1'b1;

  // Input kinds (tuser on the input)
  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0]  left_position;
    logic [LINE_W-1:0] top_position;
    logic [COL_W-1:0]  image_width;
    logic [LINE_W-1:0] image_height;
    logic [WORD_W-1:0] memory_base;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic start;       // new image: clear counters
    logic load;        // capture the incoming byte
    logic drop_run;    // zero-length run value: just clear the pending run
    logic run_load;    // load the run pixel counter
    logic header_in;   // run header taken from the incoming byte
    logic header_lat;  // run header taken from the captured byte
    logic emit_addr;   // line start address result
    logic run_step;    // one step of run expansion
    logic pix_step;    // single pixel
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;
    logic line_open;
    logic await_run;
    logic run_zero;
    logic in_header;
    logic lat_header;
    logic run_final;
    logic slot_free;
  } status_t;

  function automatic logic is_header(input logic [BYTE_W-1:0] b);
    return b[BYTE_W-1 -: 2] == RUN_MARK;
  endfunction

endpackage

@@ hw/rtl/pcxw_regs.sv @@
// ----------------------------------------------------------------------------
// pcxw_regs
// APB register file holding image placement, size and memory base.
// ----------------------------------------------------------------------------
module pcxw_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcxw_pkg::ADDR_W-1:0]   paddr,
  input  logic [pcxw_pkg::APB_W-1:0]    pwdata,
  output logic [pcxw_pkg::APB_W-1:0]    prdata,
  output logic                          pready,
  output pcxw_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_position <= '0;
      cfg.top_position  <= '0;
      cfg.image_width   <= pcxw_pkg::WIDTH_RST;
      cfg.image_height  <= pcxw_pkg::HEIGHT_RST;
      cfg.memory_base   <= '0;
    end else if (wr_en) begin
      case (idx)
        pcxw_pkg::REG_LEFT_POS: cfg.left_position <= pwdata[pcxw_pkg::COL_W-1:0];
        pcxw_pkg::REG_TOP_POS:  cfg.top_position  <= pwdata[pcxw_pkg::LINE_W-1:0];
        pcxw_pkg::REG_WIDTH:    cfg.image_width   <= pwdata[pcxw_pkg::COL_W-1:0];
        pcxw_pkg::REG_HEIGHT:   cfg.image_height  <= pwdata[pcxw_pkg::LINE_W-1:0];
        pcxw_pkg::REG_MEM_BASE: cfg.memory_base   <= pwdata[pcxw_pkg::WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      pcxw_pkg::REG_LEFT_POS: prdata = pcxw_pkg::APB_W'(cfg.left_position);
      pcxw_pkg::REG_TOP_POS:  prdata = pcxw_pkg::APB_W'(cfg.top_position);
      pcxw_pkg::REG_WIDTH:    prdata = pcxw_pkg::APB_W'(cfg.image_width);
      pcxw_pkg::REG_HEIGHT:   prdata = pcxw_pkg::APB_W'(cfg.image_height);
      pcxw_pkg::REG_MEM_BASE: prdata = pcxw_pkg::APB_W'(cfg.memory_base);
      default:                prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/pcxw_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcxw_ctrl
// Sequencer: takes one coded byte at a time and steps the datapath through
// line address, run expansion or single pixel.
// ----------------------------------------------------------------------------
module pcxw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tuser,
  output logic              s_axis_tready,
  input  pcxw_pkg::status_t st,
  output pcxw_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_PIX  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       acc;

  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (s_axis_tuser == pcxw_pkg::MODE_START) begin
            cmd.start = 1'b1;
          end else if (st.active) begin
            cmd.load = 1'b1;
            if (!st.line_open) begin
              state_next = S_ADDR;
            end else if (st.await_run) begin
              if (st.run_zero) begin
                cmd.drop_run = 1'b1;
              end else begin
                cmd.run_load = 1'b1;
                state_next   = S_RUN;
              end
            end else if (st.in_header) begin
              cmd.header_in = 1'b1;
            end else begin
              state_next = S_PIX;
            end
          end
        end
      end
      S_ADDR: begin
        if (st.slot_free) begin
          cmd.emit_addr = 1'b1;
          state_next    = S_IDLE;
          if (st.await_run) begin
            if (st.run_zero) begin
              cmd.drop_run = 1'b1;
            end else begin
              cmd.run_load = 1'b1;
              state_next   = S_RUN;
            end
          end else if (st.lat_header) begin
            cmd.header_lat = 1'b1;
          end else begin
            state_next = S_PIX;
          end
        end
      end
      S_RUN: begin
        if (st.slot_free) begin
          cmd.run_step = 1'b1;
          if (st.run_final) begin
            state_next = S_IDLE;
          end
        end
      end
      S_PIX: begin
        if (st.slot_free) begin
          cmd.pix_step = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Work only starts on a transfer
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !acc) |=> (state == S_IDLE))
    else $error("controller left idle without an input transfer");

  // A run is only entered with pixels to draw
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.run_load |-> !st.run_zero)
    else $error("run expansion started on a zero-length run");
`endif

endmodule

@@ hw/rtl/pcxw_dpath.sv @@
// ----------------------------------------------------------------------------
// pcxw_dpath
// Decoder state, line address arithmetic, pixel pairing and the output
// register.
// ----------------------------------------------------------------------------
module pcxw_dpath #(
  parameter int LINE_WORDS = pcxw_pkg::LINE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcxw_pkg::cfg_t                cfg,
  input  pcxw_pkg::cmd_t                cmd,
  output pcxw_pkg::status_t             st,
  input  logic [pcxw_pkg::BYTE_W-1:0]   s_byte,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pcxw_pkg::WORD_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int LwW   = $clog2(LINE_WORDS + 1);
  localparam int YW    = pcxw_pkg::LINE_W + 1;
  localparam int ProdW = YW + LwW;

  // Decoder state
  logic                          active, active_next;
  logic                          await_run, await_run_next;
  logic [pcxw_pkg::RUN_W-1:0]    run_count, run_count_next;
  logic [pcxw_pkg::RUN_W-1:0]    rem, rem_next;
  logic [pcxw_pkg::COL_W-1:0]    column, column_next;
  logic [pcxw_pkg::LINE_W-1:0]   line, line_next;
  logic                          line_open, line_open_next;
  logic                          held, held_next;
  logic [pcxw_pkg::BYTE_W-1:0]   held_pixel, held_pixel_next;
  logic [pcxw_pkg::BYTE_W-1:0]   byte_lat;

  // Working values
  logic [YW-1:0]                 ypos;
  logic [ProdW-1:0]              prod;
  logic [pcxw_pkg::WORD_W-1:0]   addr_val;
  logic [pcxw_pkg::RUN_W-1:0]    step_rem;
  logic                          adv_en;
  logic [pcxw_pkg::RUN_W-1:0]    adv_cnt;
  logic [pcxw_pkg::COL_W:0]      adv_sum;
  logic [pcxw_pkg::LINE_W-1:0]   line_inc;
  logic                          emit;
  logic                          emit_tgt;
  logic [pcxw_pkg::WORD_W-1:0]   emit_val;
  logic                          emit_last;

  // Line start address, wraps at 16 bits
  assign ypos     = YW'(cfg.top_position) + YW'(line);
  assign prod     = ProdW'(ypos) * ProdW'(LINE_WORDS);
  assign addr_val = cfg.memory_base + pcxw_pkg::WORD_W'(prod)
                  + pcxw_pkg::WORD_W'(cfg.left_position[pcxw_pkg::COL_W-1:1]);

  // Pixels left after one run step
  always_comb begin
    if (held && rem != '0) begin
      step_rem = rem - pcxw_pkg::RUN_W'(1);
    end else if (rem >= pcxw_pkg::RUN_W'(2)) begin
      step_rem = rem - pcxw_pkg::RUN_W'(2);
    end else begin
      step_rem = '0;
    end
  end

  // Status to the controller
  always_comb begin
    st.active     = active;
    st.line_open  = line_open;
    st.await_run  = await_run;
    st.run_zero   = (run_count == '0);
    st.in_header  = pcxw_pkg::is_header(s_byte);
    st.lat_header = pcxw_pkg::is_header(byte_lat);
    st.run_final  = (step_rem == '0);
    st.slot_free  = !m_axis_tvalid || m_axis_tready;
  end

  // Next decoder state and result
  always_comb begin
    active_next     = active;
    await_run_next  = await_run;
    run_count_next  = run_count;
    rem_next        = rem;
    column_next     = column;
    line_next       = line;
    line_open_next  = line_open;
    held_next       = held;
    held_pixel_next = held_pixel;
    adv_en          = 1'b0;
    adv_cnt         = '0;
    emit            = 1'b0;
    emit_tgt        = pcxw_pkg::TGT_DATA;
    emit_val        = '0;
    emit_last       = 1'b0;
    adv_sum         = '0;
    line_inc        = line + pcxw_pkg::LINE_W'(1);

    if (cmd.start) begin
      active_next    = (cfg.image_height != '0);
      await_run_next = 1'b0;
      run_count_next = '0;
      column_next    = '0;
      line_next      = '0;
      line_open_next = 1'b0;
      held_next      = 1'b0;
    end

    if (cmd.drop_run) begin
      await_run_next = 1'b0;
    end

    if (cmd.header_in) begin
      run_count_next = s_byte[pcxw_pkg::RUN_W-1:0];
      await_run_next = 1'b1;
    end
    if (cmd.header_lat) begin
      run_count_next = byte_lat[pcxw_pkg::RUN_W-1:0];
      await_run_next = 1'b1;
    end

    if (cmd.run_load) begin
      rem_next = run_count;
    end

    // Line start: address first, an odd pixel left over is dropped
    if (cmd.emit_addr) begin
      emit           = 1'b1;
      emit_tgt       = pcxw_pkg::TGT_ADDR;
      emit_val       = addr_val;
      emit_last      = !(await_run && run_count >= pcxw_pkg::RUN_W'(2));
      held_next      = 1'b0;
      line_open_next = 1'b1;
    end

    // Run expansion: pair with a held pixel, else two copies per word, else hold the odd pixel
    if (cmd.run_step) begin
      rem_next = step_rem;
      if (held && rem != '0) begin
        emit      = 1'b1;
        emit_val  = {held_pixel, byte_lat};
        emit_last = (step_rem < pcxw_pkg::RUN_W'(2));
        held_next = 1'b0;
      end else if (rem >= pcxw_pkg::RUN_W'(2)) begin
        emit      = 1'b1;
        emit_val  = {byte_lat, byte_lat};
        emit_last = (step_rem < pcxw_pkg::RUN_W'(2));
      end else begin
        held_next       = 1'b1;
        held_pixel_next = byte_lat;
      end
      if (step_rem == '0) begin
        await_run_next = 1'b0;
        adv_en         = 1'b1;
        adv_cnt        = run_count;
      end
    end

    // Single pixel
    if (cmd.pix_step) begin
      if (held) begin
        emit      = 1'b1;
        emit_val  = {held_pixel, byte_lat};
        emit_last = 1'b1;
        held_next = 1'b0;
      end else begin
        held_next       = 1'b1;
        held_pixel_next = byte_lat;
      end
      adv_en  = 1'b1;
      adv_cnt = pcxw_pkg::RUN_W'(1);
    end

    // Column advance and line end
    if (adv_en) begin
      adv_sum = (pcxw_pkg::COL_W+1)'(column) + (pcxw_pkg::COL_W+1)'(adv_cnt);
      if (adv_sum >= (pcxw_pkg::COL_W+1)'(cfg.image_width)) begin
        column_next    = '0;
        line_open_next = 1'b0;
        line_next      = line_inc;
        if (line_inc >= cfg.image_height) begin
          active_next = 1'b0;
          held_next   = 1'b0;
        end
      end else begin
        column_next = adv_sum[pcxw_pkg::COL_W-1:0];
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      await_run <= 1'b0;
      run_count <= '0;
      rem       <= '0;
      column    <= '0;
      line      <= '0;
      line_open <= 1'b0;
      held      <= 1'b0;
    end else begin
      active    <= active_next;
      await_run <= await_run_next;
      run_count <= run_count_next;
      rem       <= rem_next;
      column    <= column_next;
      line      <= line_next;
      line_open <= line_open_next;
      held      <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    held_pixel <= held_pixel_next;
    if (cmd.load) begin
      byte_lat <= s_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= emit_val;
      m_axis_tuser <= emit_tgt;
      m_axis_tlast <= emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  // A result is only written into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending output transfer");

  // Run steps only happen with pixels pending
  a_step_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.run_step |-> (rem != '0))
    else $error("run step with no pixels left");

  // A new image starts at the top left with no line open
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (line == '0 && column == '0 && !line_open && !held))
    else $error("start did not clear the position");
`endif

endmodule

@@ hw/rtl/pcx_rle_pixel_word_writer_core.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_pixel_word_writer_core
// Decodes PCX run-length coded bytes into video-memory address and pixel
// word writes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake         payload
//  s_axis    in         tvalid / tready   tuser = mode, tdata = coded_byte
//  m_axis    out        tvalid / tready   tuser = target, tdata = word_value,
//                                         tlast = last
//  apb       in         psel / penable    5 registers at byte address 4*i
//
//  One input byte at a time. A run header or an ignored byte is handled in
//  idle, a single pixel in the pixel state and a run value in run expansion,
//  each after the address state at a line start; a run may leave a pixel held.
//  The output register lets the next byte in while a result waits.
//  Output back-pressure stalls the sequencer before each result.
//  Reset is synchronous, active high; the block then idles until a start.
//
module pcx_rle_pixel_word_writer_core #(
  parameter int LINE_WORDS = pcxw_pkg::LINE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Coded byte input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pcxw_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] coded_byte
  input  logic                          s_axis_tuser,   // [0] mode
  // Result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pcxw_pkg::WORD_W-1:0]   m_axis_tdata,   // [15:0] word_value
  output logic                          m_axis_tuser,   // [0] target
  output logic                          m_axis_tlast,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcxw_pkg::ADDR_W-1:0]   paddr,
  input  logic [pcxw_pkg::APB_W-1:0]    pwdata,
  output logic [pcxw_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);

  pcxw_pkg::cfg_t    cfg;
  pcxw_pkg::cmd_t    cmd;
  pcxw_pkg::status_t st;

  // Register file
  pcxw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  pcxw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  // Datapath and output register
  pcxw_dpath #(
    .LINE_WORDS (LINE_WORDS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .st            (st),
    .s_byte        (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ bench/pcx_rle_pixel_word_writer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcx_rle_pixel_word_writer_checker
// Watches the coded byte stream, the register port and the result stream of
// the PCX word writer. Keeps its own decoder state, builds the expected
// address and pixel word writes for every byte taken in, and compares each
// result transfer with the oldest one waiting.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_word_writer_checker #(
  parameter int LINE_WORDS = pcxw_pkg::LINE_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [pcxw_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] coded_byte
  input  logic                        s_axis_tuser,   // [0] mode
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [pcxw_pkg::WORD_W-1:0] m_axis_tdata,   // [15:0] word_value
  input  logic                        m_axis_tuser,   // [0] target
  input  logic                        m_axis_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [pcxw_pkg::ADDR_W-1:0] paddr,
  input  logic [pcxw_pkg::APB_W-1:0]  pwdata,
  output int                          mismatch_count,
  output int                          outstanding,
  output logic                        decoding
);
  import pcxw_pkg::*;

  typedef struct packed {
    logic              target;
    logic [WORD_W-1:0] value;
    logic              last;
  } word_write_t;

  word_write_t expected_q[$];

  // Register copies
  logic [COL_W-1:0]  left_pos, img_w;
  logic [LINE_W-1:0] top_pos, img_h;
  logic [WORD_W-1:0] mem_base;

  // Decoder state
  logic              active, awaiting_value, pixel_held, line_open;
  logic [RUN_W-1:0]  run_len;
  logic [COL_W-1:0]  col;
  logic [LINE_W-1:0] row;
  logic [BYTE_W-1:0] held_px;

  task automatic push_word(input logic tgt, input logic [WORD_W-1:0] val);
    word_write_t w;
    w.target = tgt;
    w.value  = val;
    w.last   = 1'b0;
    expected_q.push_back(w);
  endtask

  // Pair pixels, first one in the high byte
  task automatic put_pixel(input logic [BYTE_W-1:0] px);
    if (pixel_held) begin
      pixel_held = 1'b0;
      push_word(TGT_DATA, {held_px, px});
    end else begin
      held_px    = px;
      pixel_held = 1'b1;
    end
  endtask

  // Move along the line; close it once the image width is reached
  task automatic step_column(input int unsigned count);
    int unsigned c;
    c = 32'(col) + count;
    if (c >= 32'(img_w)) begin
      col       = '0;
      line_open = 1'b0;
      row       = row + 8'd1;
      if (row >= img_h) begin
        active     = 1'b0;
        pixel_held = 1'b0;
      end
    end else begin
      col = c[COL_W-1:0];
    end
  endtask

  task automatic decode_byte(input logic mode, input logic [BYTE_W-1:0] b);
    int unsigned addr;
    int unsigned first;
    word_write_t tail;
    first = expected_q.size();
    if (mode == MODE_START) begin
      awaiting_value = 1'b0;
      run_len        = '0;
      col            = '0;
      row            = '0;
      line_open      = 1'b0;
      pixel_held     = 1'b0;
      active         = (img_h != '0);
      return;
    end
    if (!active) return;

    // Line start address, any unpaired pixel is lost
    if (!line_open) begin
      addr = 32'(mem_base) + (32'(top_pos) + 32'(row)) * LINE_WORDS
           + 32'(left_pos >> 1);
      push_word(TGT_ADDR, addr[WORD_W-1:0]);
      pixel_held = 1'b0;
      line_open  = 1'b1;
    end

    if (awaiting_value) begin
      awaiting_value = 1'b0;
      for (int i = 0; i < int'(run_len); i++) put_pixel(b);
      if (run_len != '0) step_column(32'(run_len));
    end else if (b[BYTE_W-1 -: 2] == RUN_MARK) begin
      run_len        = b[RUN_W-1:0];
      awaiting_value = 1'b1;
    end else begin
      put_pixel(b);
      step_column(1);
    end

    if (expected_q.size() > first) begin
      tail      = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : monitor
    word_write_t got, want;
    if (rst) begin
      left_pos       = '0;
      top_pos        = '0;
      img_w          = WIDTH_RST;
      img_h          = HEIGHT_RST;
      mem_base       = '0;
      active         = 1'b0;
      awaiting_value = 1'b0;
      pixel_held     = 1'b0;
      line_open      = 1'b0;
      run_len        = '0;
      col            = '0;
      row            = '0;
      held_px        = '0;
      mismatch_count = 0;
      expected_q.delete();
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_LEFT_POS: left_pos = pwdata[COL_W-1:0];
          REG_TOP_POS:  top_pos  = pwdata[LINE_W-1:0];
          REG_WIDTH:    img_w    = pwdata[COL_W-1:0];
          REG_HEIGHT:   img_h    = pwdata[LINE_W-1:0];
          REG_MEM_BASE: mem_base = pwdata[WORD_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tuser, s_axis_tdata);

      // Result transfer against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got.target = m_axis_tuser;
        got.value  = m_axis_tdata;
        got.last   = m_axis_tlast;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result: target %0d word %h last %0d",
                     $time, got.target, got.value, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected target %0d word %h last %0d,",
                       $time, want.target, want.value, want.last,
                       " got target %0d word %h last %0d",
                       got.target, got.value, got.last);
          end
        end
      end
    end
    outstanding <= expected_q.size();
    decoding    <= active;
  end

endmodule

@@ bench/pcx_rle_pixel_word_writer_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcx_rle_pixel_word_writer_core_tb
// Drives coded PCX byte streams and register settings into the word writer,
// with random stalls on both streams; the checker beside the block predicts
// and compares every address and pixel word write.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_word_writer_core_tb;
  import pcxw_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 64;

  logic              clk;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata  = '0;   // [7:0] coded_byte
  logic              s_axis_tuser  = 1'b0; // [0] mode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [WORD_W-1:0] m_axis_tdata;         // [15:0] word_value
  logic              m_axis_tuser;         // [0] target
  logic              m_axis_tlast;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [APB_W-1:0]  pwdata        = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  int   mismatch_count;
  int   outstanding;
  logic decoding;

  int stall_pct  = 25;
  int gap_pct    = 25;
  int stall_left = 0;
  int cycles     = 0;
  int phase_items;

  pcx_rle_pixel_word_writer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pcx_rle_pixel_word_writer_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .decoding       (decoding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result sink: random back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left    <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Setup and access cycle; the register takes the value on the access edge
  task automatic apb_write(input logic [2:0] idx, input logic [APB_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random bits above the register width must be ignored
  function automatic logic [APB_W-1:0] with_junk(input int unsigned val, input int w);
    return ($urandom << w) | val;
  endfunction

  task automatic set_image(input int unsigned left, input int unsigned top,
                           input int unsigned width, input int unsigned height,
                           input int unsigned base);
    apb_write(REG_LEFT_POS, with_junk(left, COL_W));
    apb_write(REG_TOP_POS,  with_junk(top, LINE_W));
    apb_write(REG_WIDTH,    with_junk(width, COL_W));
    apb_write(REG_HEIGHT,   with_junk(height, LINE_W));
    apb_write(REG_MEM_BASE, with_junk(base, WORD_W));
  endtask

  // One byte transfer, then maybe a gap on the input
  task automatic transfer_byte(input logic mode, input logic [BYTE_W-1:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Wait for every expected write, then for bytes that give none
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed runs and pixels, with some noise and early restarts
  task automatic random_token();
    int pick;
    logic [RUN_W-1:0] count;
    pick = $urandom_range(0, 99);
    if (!decoding) begin
      if (pick < 85) transfer_byte(MODE_START, BYTE_W'($urandom_range(0, 255)));
      else transfer_byte(MODE_DATA, BYTE_W'($urandom_range(0, 255)));
    end else begin
      phase_items++;
      if (pick < 45) begin
        count = (pick < 30) ? RUN_W'($urandom_range(0, 7)) : RUN_W'($urandom_range(0, 63));
        transfer_byte(MODE_DATA, {RUN_MARK, count});
        transfer_byte(MODE_DATA, BYTE_W'($urandom_range(0, 255)));
        phase_items++;
      end else if (pick < 85) begin
        transfer_byte(MODE_DATA, BYTE_W'($urandom_range(0, 8'hBF)));
      end else if (pick < 96) begin
        transfer_byte(MODE_DATA, BYTE_W'($urandom_range(0, 255)));
      end else begin
        transfer_byte(MODE_START, BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_phase(input int items, input int stall, input int gap);
    stall_pct   = stall;
    gap_pct     = gap;
    phase_items = 0;
    while (phase_items < items) random_token();
    drain();
  endtask

  task automatic random_image();
    int unsigned width, height;
    width  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 24) : $urandom_range(0, 320);
    height = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(1, 240);
    set_image($urandom_range(0, 319), $urandom_range(0, 239), width, height,
              $urandom_range(0, 65535));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, full-size image
    transfer_byte(MODE_DATA, 8'h41);    // idle, ignored
    transfer_byte(MODE_START, 8'h00);
    transfer_byte(MODE_DATA, 8'hC0);    // zero-length run opens the line
    transfer_byte(MODE_DATA, 8'h55);
    transfer_byte(MODE_DATA, 8'h00);
    transfer_byte(MODE_DATA, 8'hBF);
    transfer_byte(MODE_DATA, 8'hFF);    // longest run
    transfer_byte(MODE_DATA, 8'hFF);
    transfer_byte(MODE_DATA, 8'h80);
    transfer_byte(MODE_DATA, 8'hC2);    // run cut short by a restart
    transfer_byte(MODE_START, 8'hFF);
    transfer_byte(MODE_DATA, 8'h33);
    drain();

    // Directed: far corner, wrapping address, short lines
    set_image(319, 239, 6, 2, 32'hFFFF);
    transfer_byte(MODE_START, 8'h00);
    transfer_byte(MODE_DATA, 8'hC7);    // run past the line end, odd length
    transfer_byte(MODE_DATA, 8'hA5);
    transfer_byte(MODE_DATA, 8'h7F);    // held pixel dropped at line start
    transfer_byte(MODE_DATA, 8'hC0);
    transfer_byte(MODE_DATA, 8'hC1);    // zero run, value looks like a header
    transfer_byte(MODE_DATA, 8'hC5);
    transfer_byte(MODE_DATA, 8'h3C);    // last line ends, image done
    transfer_byte(MODE_DATA, 8'h12);    // ignored
    drain();

    // Directed: zero width, then zero height
    set_image(0, 0, 0, 1, 0);
    transfer_byte(MODE_START, 8'h00);
    transfer_byte(MODE_DATA, 8'h01);
    transfer_byte(MODE_DATA, 8'h02);    // ignored
    drain();
    set_image(0, 0, 0, 0, 0);
    transfer_byte(MODE_START, 8'h00);
    transfer_byte(MODE_DATA, 8'hC3);    // still idle
    drain();

    // Random phases
    random_image();
    random_phase(70, 30, 30);
    set_image(0, 0, 320, 240, 0);
    random_phase(60, 0, 0);
    set_image(319, 239, 0, 240, 32'hFFFF);
    random_phase(60, 50, 40);
    random_image();
    random_phase(70, 15, 15);
    random_image();
    random_phase(70, 40, 50);
    random_image();
    random_phase(70, 0, 0);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pcxw_pkg.sv
hw/rtl/pcxw_regs.sv
hw/rtl/pcxw_ctrl.sv
hw/rtl/pcxw_dpath.sv
hw/rtl/pcx_rle_pixel_word_writer_core.sv
bench/pcx_rle_pixel_word_writer_checker.sv
bench/pcx_rle_pixel_word_writer_core_tb.sv
